// ===== src/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

    localparam int BYTE_W    = 8;
    localparam int UNIT_W    = 16;
    localparam int PENDING_W = 3;

    // Lead byte classification masks.
    localparam logic [BYTE_W-1:0] LEAD_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] BIT_TWO    = 8'h20;
    localparam logic [BYTE_W-1:0] BIT_THREE  = 8'h10;
    localparam logic [BYTE_W-1:0] BIT_FOUR   = 8'h08;
    localparam logic [BYTE_W-1:0] BIT_FIVE   = 8'h04;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] TWO_MASK   = 8'h1F;
    localparam logic [BYTE_W-1:0] THREE_MASK = 8'h0F;

    localparam logic [UNIT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Number of bytes that follow each lead type.
    localparam logic [PENDING_W-1:0] FOLLOW_TWO   = 3'd1;
    localparam logic [PENDING_W-1:0] FOLLOW_THREE = 3'd2;
    localparam logic [PENDING_W-1:0] FOLLOW_FOUR  = 3'd3;
    localparam logic [PENDING_W-1:0] FOLLOW_FIVE  = 3'd4;
    localparam logic [PENDING_W-1:0] FOLLOW_SIX   = 3'd5;

    // One decoded result, with a flag telling whether the byte produced one.
    typedef struct packed {
        logic              valid;
        logic [UNIT_W-1:0] code_unit;
        logic              is_end;
        logic [UNIT_W-1:0] unit_count;
    } utf8d_result_t;

endpackage

`default_nettype wire

// ===== src/utf8_to_ucs2_decoder.sv =====
// Path: a byte accepted into the input register is decoded and registered
// in the result register, which drives out_valid; out_ready can stall it.
// Throughput: one byte per cycle, set by the single decode step between the
// input register and the result register; stalls only from out_ready.
// Reset: rst_n clears the sequence state, unit count and both valid flags.
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// Decodes a UTF-8 byte stream into 16-bit code units with string terminators.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_decoder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [utf8d_pkg::BYTE_W-1:0] in_byte,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [utf8d_pkg::UNIT_W-1:0]      code_unit,
    output logic                              is_end,
    output logic [utf8d_pkg::UNIT_W-1:0]      unit_count
);
    import utf8d_pkg::*;

    // The input register takes one byte transaction per cycle. Its byte moves
    // into the decode step whenever the result register is empty or is being
    // emptied in the same cycle, so a finished result never blocks new input
    // for more than the time the consumer holds out_ready low.
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              take;
    logic              out_free;
    utf8d_result_t     res;

    utf8d_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    // The decode step holds the state of the sequence in progress: bytes still
    // expected, the value gathered so far, whether the sequence is being
    // discarded, and the number of units emitted since the last terminator.
    // Bytes that end no sequence produce no result transaction at all.
    utf8d_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .out_free   (out_free),
        .take       (take),
        .res        (res)
    );

    // The result register presents one result transaction until it is taken.
    utf8d_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .res        (res),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_unit  (code_unit),
        .is_end     (is_end),
        .unit_count (unit_count)
    );

endmodule

`default_nettype wire

// ===== src/utf8d_in_stage.sv =====
// ----------------------------------------------------------------------------
// utf8d_in_stage
// Input register that holds one byte until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_in_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [utf8d_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                        take,
    output logic                             byte_valid,
    output logic [utf8d_pkg::BYTE_W-1:0]     byte_data
);
    import utf8d_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // The register can be refilled in the same cycle that its byte moves on.
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

`default_nettype wire

// ===== src/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and the single-pass decode of one byte into a result.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_decode (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         byte_valid,
    input  wire logic [utf8d_pkg::BYTE_W-1:0] byte_data,
    input  wire logic                         out_free,
    output logic                              take,
    output utf8d_pkg::utf8d_result_t          res
);
    import utf8d_pkg::*;

    logic [PENDING_W-1:0] pending_reg;
    logic [PENDING_W-1:0] pending_next;
    logic [UNIT_W-1:0]    partial_reg;
    logic [UNIT_W-1:0]    partial_next;
    logic                 dropping_reg;
    logic                 dropping_next;
    logic [UNIT_W-1:0]    count_reg;
    logic [UNIT_W-1:0]    count_next;
    logic [UNIT_W-1:0]    count_inc;
    logic [UNIT_W-1:0]    shifted;

    assign take      = byte_valid && out_free;
    assign count_inc = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign shifted   = {partial_reg[UNIT_W-7:0], byte_data[5:0]};

    always_comb
    begin
        pending_next  = pending_reg;
        partial_next  = partial_reg;
        dropping_next = dropping_reg;
        count_next    = count_reg;
        res           = '0;

        if (pending_reg != '0)
        begin
            pending_next = pending_reg - 1'b1;
            if (dropping_reg)
            begin
                dropping_next = (pending_next != '0);
            end
            else
            begin
                partial_next = shifted;
                if (pending_next == '0)
                begin
                    res.valid     = 1'b1;
                    res.code_unit = shifted;
                    count_next    = count_inc;
                end
            end
        end
        else if (byte_data == '0)
        begin
            // End of string: report the count and start a new one.
            res.valid      = 1'b1;
            res.is_end     = 1'b1;
            res.unit_count = count_reg;
            count_next     = '0;
        end
        else if ((byte_data & LEAD_MASK) != LEAD_MASK)
        begin
            res.valid     = 1'b1;
            res.code_unit = {{(UNIT_W-BYTE_W){1'b0}}, byte_data};
            count_next    = count_inc;
        end
        else if ((byte_data & BIT_TWO) == '0)
        begin
            partial_next = {{(UNIT_W-BYTE_W){1'b0}}, byte_data & TWO_MASK};
            pending_next = FOLLOW_TWO;
        end
        else if ((byte_data & BIT_THREE) == '0)
        begin
            partial_next = {{(UNIT_W-BYTE_W){1'b0}}, byte_data & THREE_MASK};
            pending_next = FOLLOW_THREE;
        end
        else
        begin
            // Four, five and six byte sequences do not fit a 16-bit unit.
            dropping_next = 1'b1;
            partial_next  = '0;
            if ((byte_data & BIT_FOUR) == '0)
            begin
                pending_next = FOLLOW_FOUR;
            end
            else if ((byte_data & BIT_FIVE) == '0)
            begin
                pending_next = FOLLOW_FIVE;
            end
            else
            begin
                pending_next = FOLLOW_SIX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            partial_reg  <= '0;
            dropping_reg <= 1'b0;
            count_reg    <= '0;
        end
        else if (take)
        begin
            pending_reg  <= pending_next;
            partial_reg  <= partial_next;
            dropping_reg <= dropping_next;
            count_reg    <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_drop_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> pending_reg != '0)
        else $error("dropping without pending bytes");

    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= FOLLOW_SIX)
        else $error("pending byte count out of range");

    a_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        take && res.valid && res.is_end |=> count_reg == '0)
        else $error("unit count not cleared after terminator");

    a_end_unit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.is_end |-> res.code_unit == '0)
        else $error("terminator carries a nonzero code unit");
`endif

endmodule

`default_nettype wire

// ===== src/utf8d_out_stage.sv =====
// ----------------------------------------------------------------------------
// utf8d_out_stage
// Result register that holds one decoded transaction for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_out_stage (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire utf8d_pkg::utf8d_result_t     res,
    output logic                              out_free,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [utf8d_pkg::UNIT_W-1:0]      code_unit,
    output logic                              is_end,
    output logic [utf8d_pkg::UNIT_W-1:0]      unit_count
);
    import utf8d_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [UNIT_W-1:0] code_unit_reg;
    logic              is_end_reg;
    logic [UNIT_W-1:0] unit_count_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res.valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            code_unit_reg  <= res.code_unit;
            is_end_reg     <= res.is_end;
            unit_count_reg <= res.unit_count;
        end
    end

    assign out_valid  = valid_reg;
    assign code_unit  = code_unit_reg;
    assign is_end     = is_end_reg;
    assign unit_count = unit_count_reg;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to UCS-2 decoder. A scoreboard decodes
// every byte the block accepts and checks each code unit it hands out.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import utf8d_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_BYTES   = 1400;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int SHOWN_ERRORS   = 25;

    // Decodes accepted bytes into the code units the block should produce.
    // It keeps its own copy of the sequence state. Units wait in a queue,
    // oldest first, until the block hands out the matching transaction.
    class ucs2_scoreboard;
        logic [PENDING_W-1:0] follow_left;
        logic [UNIT_W-1:0]    partial;
        bit                   dropping;
        logic [UNIT_W-1:0]    units_in_string;
        utf8d_result_t        units_due[$];

        int mismatches;
        int bytes_seen;
        int units_checked;
        int terminators;
        int dropped_sequences;

        function new();
            follow_left     = '0;
            partial         = '0;
            dropping        = 1'b0;
            units_in_string = '0;
            mismatches      = 0;
            bytes_seen      = 0;
            units_checked   = 0;
            terminators     = 0;
            dropped_sequences = 0;
        endfunction

        task report(input string msg);
            if (mismatches < SHOWN_ERRORS)
                $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        function void push_unit(input logic [UNIT_W-1:0] value, input logic end_flag,
                                input logic [UNIT_W-1:0] count);
            utf8d_result_t unit;
            unit.valid      = 1'b1;
            unit.code_unit  = value;
            unit.is_end     = end_flag;
            unit.unit_count = count;
            units_due.push_back(unit);
        endfunction

        function void emit_unit(input logic [UNIT_W-1:0] value);
            push_unit(value, 1'b0, '0);
            if (units_in_string != COUNT_MAX)
                units_in_string = units_in_string + 16'd1;
        endfunction

        // Called for each accepted input transaction.
        function void decode_byte(input logic [BYTE_W-1:0] b);
            bytes_seen++;
            if (follow_left != '0)
            begin
                // Continuation bytes are taken blindly, zero included.
                follow_left = follow_left - 3'd1;
                if (dropping)
                begin
                    if (follow_left == '0)
                        dropping = 1'b0;
                end
                else
                begin
                    partial = {partial[UNIT_W-7:0], b[5:0]};
                    if (follow_left == '0)
                        emit_unit(partial);
                end
            end
            else if (b == '0)
            begin
                push_unit('0, 1'b1, units_in_string);
                units_in_string = '0;
            end
            else if ((b & LEAD_MASK) != LEAD_MASK)
            begin
                emit_unit(16'(b));
            end
            else if ((b & BIT_TWO) == '0)
            begin
                partial     = 16'(b & TWO_MASK);
                follow_left = FOLLOW_TWO;
            end
            else if ((b & BIT_THREE) == '0)
            begin
                partial     = 16'(b & THREE_MASK);
                follow_left = FOLLOW_THREE;
            end
            else
            begin
                dropping = 1'b1;
                partial  = '0;
                dropped_sequences++;
                if ((b & BIT_FOUR) == '0)
                    follow_left = FOLLOW_FOUR;
                else if ((b & BIT_FIVE) == '0)
                    follow_left = FOLLOW_FIVE;
                else
                    follow_left = FOLLOW_SIX;
            end
        endfunction

        // Called for each accepted output transaction.
        task check_unit(input logic [UNIT_W-1:0] value, input logic end_flag,
                        input logic [UNIT_W-1:0] count);
            utf8d_result_t unit;
            if (units_due.size() == 0)
            begin
                report($sformatf("unit %0d arrived with nothing expected (unit %h end %b)",
                                 units_checked, value, end_flag));
            end
            else
            begin
                unit = units_due.pop_front();
                if (value !== unit.code_unit)
                    report($sformatf("unit %0d code_unit expected %h got %h",
                                     units_checked, unit.code_unit, value));
                if (end_flag !== unit.is_end)
                    report($sformatf("unit %0d is_end expected %b got %b",
                                     units_checked, unit.is_end, end_flag));
                if (count !== unit.unit_count)
                    report($sformatf("unit %0d unit_count expected %0d got %0d",
                                     units_checked, unit.unit_count, count));
                if (unit.is_end)
                    terminators++;
            end
            units_checked++;
        endtask

        task finish_check();
            if (units_due.size() != 0)
                report($sformatf("%0d expected units never arrived", units_due.size()));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [BYTE_W-1:0]   in_byte;
    logic                out_valid;
    logic                out_ready;
    logic [UNIT_W-1:0]   code_unit;
    logic                is_end;
    logic [UNIT_W-1:0]   unit_count;

    ucs2_scoreboard sb;

    // Knobs and counters for the stimulus, the receiver and the sampling process.
    bit gaps_on;
    bit hold_armed;
    bit hold_done;
    int hold_at;
    int burst_left;
    int input_stall_cycles;

    utf8_to_ucs2_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_unit  (code_unit),
        .is_end     (is_end),
        .unit_count (unit_count)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // All sampling happens at the rising edge, before any nonblocking update
    // of that edge lands, so both the bench and the block see the same
    // pre-edge values. The input side is noted first so that a result can
    // never be compared before the byte that caused it is on record.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.decode_byte(in_byte);
            if (in_valid && !in_ready)
                input_stall_cycles++;
            if (out_valid && out_ready)
                sb.check_unit(code_unit, is_end, unit_count);
        end
    end

    // Offers one byte and returns at the edge where the transaction is taken.
    // The sender works in bursts; between bursts valid drops for a random
    // stretch. Back-to-back bytes keep valid high without a low blip, since
    // the only assignment in that step raises it again.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            // Now and then a long burst gives a stretch with no idling at all.
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(60, 150);
            else
                burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // One random sequence. Most are well formed with random payload bits; the
    // rest are terminators, long leads, broken continuations and noise bytes.
    task automatic send_random_sequence(inout int sent);
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 28)
        begin
            send_byte(8'($urandom_range(1, 127)));
            sent += 1;
        end
        else if (kind < 43)
        begin
            send_byte(8'hC0 | 8'($urandom_range(0, 31)));
            send_byte(cont_byte());
            sent += 2;
        end
        else if (kind < 58)
        begin
            send_byte(8'hE0 | 8'($urandom_range(0, 15)));
            send_byte(cont_byte());
            send_byte(cont_byte());
            sent += 3;
        end
        else if (kind < 63)
        begin
            send_byte(8'hF0 | 8'($urandom_range(0, 7)));
            for (n = 0; n < 3; n++)
                send_byte(8'($urandom_range(0, 255)));
            sent += 4;
        end
        else if (kind < 66)
        begin
            send_byte(8'hF8 | 8'($urandom_range(0, 3)));
            for (n = 0; n < 4; n++)
                send_byte(8'($urandom_range(0, 255)));
            sent += 5;
        end
        else if (kind < 69)
        begin
            send_byte(8'hFC | 8'($urandom_range(0, 3)));
            for (n = 0; n < 5; n++)
                send_byte(8'($urandom_range(0, 255)));
            sent += 6;
        end
        else if (kind < 75)
        begin
            send_byte(8'h00);
            sent += 1;
        end
        else if (kind < 84)
        begin
            // Lead byte followed by anything, zeros and lead bytes included.
            if (kind < 80)
            begin
                send_byte(8'hC0 | 8'($urandom_range(0, 31)));
                send_byte(8'($urandom_range(0, 255)));
                sent += 2;
            end
            else
            begin
                send_byte(8'hE0 | 8'($urandom_range(0, 15)));
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
                sent += 3;
            end
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)));
            sent += 1;
        end
    endtask

    // Receiver: out_ready follows a 16-bit pattern, redrawn once all of its
    // bits are used, from always ready to mostly stalled. Once, after the
    // random phase has started, it holds off for a long stretch while the
    // sender keeps offering bytes, so the block backs up into its input.
    initial
    begin : receiver
        logic [15:0] pattern;
        int          phase;
        pattern = 16'hFFFF;
        phase   = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_armed && !hold_done && sb.units_checked >= hold_at)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (phase == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       pattern = 16'hFFFF;
                        1:       pattern = 16'($urandom);
                        2:       pattern = 16'($urandom) | 16'($urandom);
                        default: pattern = 16'($urandom) & 16'($urandom);
                    endcase
                end
                out_ready <= pattern[phase];
                phase = (phase + 1) % 16;
                @(posedge clk);
            end
        end
    end

    // Main stimulus: directed bytes, then random sequences with idling on
    // both sides.
    initial
    begin : stimulus
        logic [BYTE_W-1:0] directed_bytes [0:25];
        int sent;
        int i;

        sb = new();
        gaps_on            = 1'b0;
        hold_armed         = 1'b0;
        hold_done          = 1'b0;
        hold_at            = 0;
        burst_left         = 0;
        input_stall_cycles = 0;
        sent               = 0;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty string; pass-through of 7F and a stray 80; a 2-byte lead
        // with a continuation whose top bits are wrong; the widest 3-byte
        // value; a zero inside a sequence that must not end the string;
        // all three dropped lead types, with zeros among the skipped bytes;
        // and a final terminator that should report five units.
        directed_bytes = '{8'h00, 8'h7F, 8'h80, 8'hC0, 8'hFF, 8'hEF, 8'hBF, 8'hBF,
                           8'hC1, 8'h00, 8'hF0, 8'h01, 8'h02, 8'h03, 8'hF8, 8'h00,
                           8'h80, 8'hC0, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                           8'h00, 8'h00};
        gaps_on = 1'b1;
        for (i = 0; i < 26; i++)
            send_byte(directed_bytes[i]);

        hold_at    = sb.units_checked + 200;
        hold_armed = 1'b1;
        while (sent < RANDOM_BYTES)
            send_random_sequence(sent);
        send_byte(8'h00);

        // The last byte went in at this edge; its expectation is recorded by
        // now once the next edge has passed.
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.units_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.finish_check();

        $display("Run covered %0d bytes, %0d code units and %0d terminators,",
                 sb.bytes_seen, sb.units_checked, sb.terminators);
        $display("and %0d dropped sequences; input back-pressure lasted %0d cycles.",
                 sb.dropped_sequences, input_stall_cycles);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("Timeout with %0d units still expected", sb.units_due.size());
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/utf8d_pkg.sv
src/utf8d_in_stage.sv
src/utf8d_decode.sv
src/utf8d_out_stage.sv
src/utf8_to_ucs2_decoder.sv
bench/tb.sv
